/* rtl/packet_route_matcher_assert.svh */
// Assertion helpers used by the route matcher RTL.
`ifndef PACKET_ROUTE_MATCHER_ASSERT_SVH
`define PACKET_ROUTE_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PRM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packet_route_matcher: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packet_route_matcher: next-cycle check failed");

`endif

/* rtl/prm_pkg.sv */
package prm_pkg;

  localparam int FLAG_W      = 16;
  localparam int TAG_W       = 32;
  localparam int COUNT_W     = 3;
  localparam int ROUTE_NUM_W = 2;
  localparam int MASK_REGS   = 4;
  localparam int CFG_DATA_W  = 16;

  localparam int NUM_ROUTES_DEFAULT = 4;
  localparam int FLAG_BITS_DEFAULT  = 16;

  typedef enum logic [2:0] {
    REG_ROUTE_COUNT = 3'd0,
    REG_MASK_ROUTE0 = 3'd1,
    REG_MASK_ROUTE1 = 3'd2,
    REG_MASK_ROUTE2 = 3'd3,
    REG_MASK_ROUTE3 = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_DROP = 1'b1
  } status_t;

endpackage

/* rtl/prm_if.sv */
interface prm_pkt_if;
  logic                       valid;
  logic                       ready;
  logic [prm_pkg::FLAG_W-1:0] flag_word;
  logic                       carries_source;
  logic [prm_pkg::TAG_W-1:0]  source_tag;

  modport source (output valid, output flag_word, output carries_source,
                  output source_tag, input ready);
  modport sink (input valid, input flag_word, input carries_source,
                input source_tag, output ready);
endinterface

interface prm_res_if;
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic                            route_found;
  logic [prm_pkg::ROUTE_NUM_W-1:0] route_number;
  prm_pkg::status_t                drop_status;
  logic                            route_has_source;
  logic [prm_pkg::TAG_W-1:0]       route_source;

  modport source (output valid, output accepted, output route_found,
                  output route_number, output drop_status,
                  output route_has_source, output route_source, input ready);
  modport sink (input valid, input accepted, input route_found,
                input route_number, input drop_status,
                input route_has_source, input route_source, output ready);
endinterface

interface prm_cfg_if;
  logic                           valid;
  logic                           ready;
  prm_pkg::cfg_reg_t              index;
  logic [prm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/packet_route_matcher.sv */
// Packet route matcher.
// Channels: packet (sink) takes a header of flags, a source-present bit and
// a source id; result (source) returns one item per packet with the accept
// decision, the matched route and that route's learned source state; cfg
// (sink) writes route_count and the four route masks and is always ready.
// A packet taken into the input register moves on once the skid entry is
// empty: into the result register, or into the skid entry if a result still
// waits there unpopped; results leave only from the result register.
// Throughput: one packet per cycle while the result side keeps up; the mask
// compare, first-match pick and per-route source check all sit between the
// input register and the result register.
// The result register is backed by a one-entry skid buffer, so a new packet
// is still taken while one result waits; packet.ready drops only once both
// hold results and the input register is also full.
// Reset clears the route count, masks, all learned route state and every
// valid flag; no sweep is needed, the block is ready on the first cycle.
// Configuration is meant to be written only while the block is idle.
`include "packet_route_matcher_assert.svh"

module packet_route_matcher #(
  parameter int NUM_ROUTES = prm_pkg::NUM_ROUTES_DEFAULT,
  parameter int FLAG_BITS  = prm_pkg::FLAG_BITS_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  prm_pkt_if.sink  packet,
  prm_res_if.source result,
  prm_cfg_if.sink  cfg
);

  localparam int FLAG_W  = prm_pkg::FLAG_W;
  localparam int TAG_W   = prm_pkg::TAG_W;
  localparam int COUNT_W = prm_pkg::COUNT_W;
  localparam int RIDX_W  = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
  localparam int MASK_N  = (NUM_ROUTES < prm_pkg::MASK_REGS) ? NUM_ROUTES
                                                            : prm_pkg::MASK_REGS;
  localparam int CMP_W   = (FLAG_BITS < FLAG_W) ? FLAG_BITS : FLAG_W;
  localparam logic [FLAG_W-1:0] FLAG_KEEP = {FLAG_W{1'b1}} >> (FLAG_W - CMP_W);

  typedef struct packed {
    logic                            accepted;
    logic                            route_found;
    logic [prm_pkg::ROUTE_NUM_W-1:0] route_number;
    prm_pkg::status_t                drop_status;
    logic                            route_has_source;
    logic [TAG_W-1:0]                route_source;
  } res_t;

  // Configuration registers.
  logic [COUNT_W-1:0] route_count;
  logic [FLAG_W-1:0]  mask [MASK_N];
  logic [FLAG_W-1:0]  route_mask [NUM_ROUTES];

  // Per-route learned state.
  logic [NUM_ROUTES-1:0] stream_started;
  logic [NUM_ROUTES-1:0] source_known;
  logic [TAG_W-1:0]      learned_source [NUM_ROUTES];

  // Input register.
  logic              s1_valid;
  logic [FLAG_W-1:0] s1_flags;
  logic              s1_carries;
  logic [TAG_W-1:0]  s1_tag;

  // Result register and skid entry.
  logic out_valid;
  res_t out_res;
  logic skid_valid;
  res_t skid_res;

  logic                  pkt_take;
  logic                  s1_fire;
  logic                  res_pop;
  logic [NUM_ROUTES-1:0] match;
  logic                  found;
  logic [RIDX_W-1:0]     hit;
  logic                  sel_known;
  logic                  sel_started;
  logic [TAG_W-1:0]      sel_source;
  logic                  ok;
  logic                  learn;
  logic                  start;
  logic                  known_after;
  logic [TAG_W-1:0]      source_after;
  res_t                  new_res;

  for (genvar r = 0; r < NUM_ROUTES; r++) begin : g_route
    if (r < MASK_N) begin : g_reg
      assign route_mask[r] = mask[r];
    end else begin : g_open
      // Routes past the mask registers match every packet.
      assign route_mask[r] = '0;
    end
    assign match[r] = (COUNT_W'(r) < route_count) &&
                      ((route_mask[r] & FLAG_KEEP & ~s1_flags) == '0);
  end

  assign s1_fire      = s1_valid && !skid_valid;
  assign packet.ready = !s1_valid || !skid_valid;
  assign pkt_take     = packet.valid && packet.ready;
  assign res_pop      = out_valid && result.ready;
  assign cfg.ready    = 1'b1;

  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int r = NUM_ROUTES - 1; r >= 0; r--) begin
      if (match[r]) begin
        found = 1'b1;
        hit   = RIDX_W'(r);
      end
    end
  end

  always_comb begin
    sel_known   = source_known[hit];
    sel_started = stream_started[hit];
    sel_source  = learned_source[hit];
    ok    = 1'b0;
    learn = 1'b0;
    start = 1'b0;
    if (s1_carries) begin
      if (sel_known) begin
        ok = (sel_source == s1_tag);
      end else if (!sel_started) begin
        learn = 1'b1;
        start = 1'b1;
        ok    = 1'b1;
      end
    end else if (!sel_known) begin
      start = 1'b1;
      ok    = 1'b1;
    end
    known_after  = sel_known || learn;
    source_after = learn ? s1_tag : sel_source;

    new_res = '0;
    new_res.drop_status = prm_pkg::STATUS_DROP;
    if (found) begin
      new_res.accepted         = ok;
      new_res.route_found      = 1'b1;
      new_res.route_number     = prm_pkg::ROUTE_NUM_W'(hit);
      new_res.drop_status      = ok ? prm_pkg::STATUS_OK : prm_pkg::STATUS_DROP;
      new_res.route_has_source = known_after;
      new_res.route_source     = known_after ? source_after : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count    <= '0;
      stream_started <= '0;
      source_known   <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
      for (int i = 0; i < MASK_N; i++) begin
        mask[i] <= '0;
      end
      for (int i = 0; i < NUM_ROUTES; i++) begin
        learned_source[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index) inside
          prm_pkg::REG_ROUTE_COUNT: begin
            route_count <= cfg.data[COUNT_W-1:0];
          end
          prm_pkg::REG_MASK_ROUTE0, prm_pkg::REG_MASK_ROUTE1,
          prm_pkg::REG_MASK_ROUTE2, prm_pkg::REG_MASK_ROUTE3: begin
            for (int i = 0; i < MASK_N; i++) begin
              if (cfg.index == prm_pkg::cfg_reg_t'(prm_pkg::REG_MASK_ROUTE0 + 3'(i))) begin
                mask[i] <= cfg.data;
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (s1_fire && found) begin
        if (start) begin
          stream_started[hit] <= 1'b1;
        end
        if (learn) begin
          source_known[hit]   <= 1'b1;
          learned_source[hit] <= s1_tag;
        end
      end

      if (pkt_take) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (skid_valid) begin
        if (res_pop) begin
          skid_valid <= 1'b0;
        end
      end else if (s1_fire) begin
        if (out_valid && !res_pop) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (res_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (pkt_take) begin
      s1_flags   <= packet.flag_word;
      s1_carries <= packet.carries_source;
      s1_tag     <= packet.source_tag;
    end
    if (skid_valid) begin
      if (res_pop) begin
        out_res <= skid_res;
      end
    end else if (s1_fire) begin
      if (out_valid && !res_pop) begin
        skid_res <= new_res;
      end else begin
        out_res <= new_res;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.accepted         = out_res.accepted;
  assign result.route_found      = out_res.route_found;
  assign result.route_number     = out_res.route_number;
  assign result.drop_status      = out_res.drop_status;
  assign result.route_has_source = out_res.route_has_source;
  assign result.route_source     = out_res.route_source;

  // The skid entry is only used behind a full result register.
  `PRM_ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // A route that learned a source id has also started its stream.
  `PRM_ASSERT_IMPLIES(a_known_started, clk, rst, 1'b1, (source_known & ~stream_started) == '0)
  // A learned source id is never forgotten outside reset.
  `PRM_ASSERT_NEXT(a_known_sticky, clk, rst, 1'b1,
                   (source_known & $past(source_known)) == $past(source_known))
  // An accepted packet always has a route and an ok status.
  `PRM_ASSERT_IMPLIES(a_accept_has_route, clk, rst, out_valid && out_res.accepted,
                      out_res.route_found && out_res.drop_status == prm_pkg::STATUS_OK)

endmodule

/* tb/packet_route_matcher_tb.sv */
module packet_route_matcher_tb;

  localparam int ROUTES      = prm_pkg::NUM_ROUTES_DEFAULT;
  localparam int FLAG_W      = prm_pkg::FLAG_W;
  localparam int TAG_W       = prm_pkg::TAG_W;
  localparam int COUNT_W     = prm_pkg::COUNT_W;
  localparam int ROUTE_NUM_W = prm_pkg::ROUTE_NUM_W;
  localparam int CFG_DATA_W  = prm_pkg::CFG_DATA_W;
  localparam int MASK_REGS   = prm_pkg::MASK_REGS;
  localparam int POOL        = 4;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic                   accepted;
    logic                   route_found;
    logic [ROUTE_NUM_W-1:0] route_number;
    prm_pkg::status_t       drop_status;
    logic                   route_has_source;
    logic [TAG_W-1:0]       route_source;
  } decision_t;

  // Tracks the route table and predicts the decision for every accepted header.
  class route_decision_board;
    bit [COUNT_W-1:0] route_count;
    bit [FLAG_W-1:0]  route_mask [ROUTES];
    bit               stream_started [ROUTES];
    bit               source_known [ROUTES];
    bit [TAG_W-1:0]   learned_source [ROUTES];
    decision_t        pending_decisions [$];
    int               errors;

    function void set_register(prm_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        prm_pkg::REG_ROUTE_COUNT: route_count = value[COUNT_W-1:0];
        prm_pkg::REG_MASK_ROUTE0: route_mask[0] = value[FLAG_W-1:0];
        prm_pkg::REG_MASK_ROUTE1: route_mask[1] = value[FLAG_W-1:0];
        prm_pkg::REG_MASK_ROUTE2: route_mask[2] = value[FLAG_W-1:0];
        prm_pkg::REG_MASK_ROUTE3: route_mask[3] = value[FLAG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_packet(logic [FLAG_W-1:0] flags, logic has_id, logic [TAG_W-1:0] tag);
      decision_t d;
      int active;
      int hit;
      logic ok;
      d = '0;
      active = (route_count > ROUTES) ? ROUTES : int'(route_count);
      hit = active;
      for (int i = active - 1; i >= 0; i--) begin
        if ((route_mask[i] & flags) == route_mask[i]) hit = i;
      end
      if (hit == active) begin
        d.drop_status = prm_pkg::STATUS_DROP;
        pending_decisions = {pending_decisions, d};
        return;
      end
      // A route that rejects the packet keeps its state; later routes are not tried.
      ok = 1'b0;
      if (has_id) begin
        if (source_known[hit]) begin
          ok = (learned_source[hit] == tag);
        end else if (!stream_started[hit]) begin
          learned_source[hit] = tag;
          source_known[hit] = 1'b1;
          stream_started[hit] = 1'b1;
          ok = 1'b1;
        end
      end else if (!source_known[hit]) begin
        stream_started[hit] = 1'b1;
        ok = 1'b1;
      end
      d.accepted         = ok;
      d.route_found      = 1'b1;
      d.route_number     = hit[ROUTE_NUM_W-1:0];
      d.drop_status      = ok ? prm_pkg::STATUS_OK : prm_pkg::STATUS_DROP;
      d.route_has_source = source_known[hit];
      d.route_source     = source_known[hit] ? learned_source[hit] : '0;
      pending_decisions = {pending_decisions, d};
    endfunction

    function void compare_field(string field, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_decision(decision_t got);
      decision_t want;
      if (pending_decisions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = pending_decisions.pop_front();
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("route_found", want.route_found, got.route_found);
      compare_field("route_number", want.route_number, got.route_number);
      compare_field("drop_status", want.drop_status, got.drop_status);
      compare_field("route_has_source", want.route_has_source, got.route_has_source);
      compare_field("route_source", want.route_source, got.route_source);
    endfunction
  endclass

  logic clk;
  logic rst;

  prm_pkt_if pkt_bus ();
  prm_res_if res_bus ();
  prm_cfg_if cfg_bus ();

  packet_route_matcher u_top (
    .clk   (clk),
    .rst   (rst),
    .packet(pkt_bus),
    .result(res_bus),
    .cfg   (cfg_bus)
  );

  route_decision_board board = new;

  int               pkt_gap_max   = 6;
  int               res_stall_max = 6;
  int               cycle_count   = 0;
  logic [COUNT_W-1:0] cur_count;
  logic [FLAG_W-1:0]  cur_mask [MASK_REGS];
  logic [TAG_W-1:0]   tag_pool [POOL];
  decision_t          seen;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure before every transaction.
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, res_stall_max);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      seen.accepted         = res_bus.accepted;
      seen.route_found      = res_bus.route_found;
      seen.route_number     = res_bus.route_number;
      seen.drop_status      = res_bus.drop_status;
      seen.route_has_source = res_bus.route_has_source;
      seen.route_source     = res_bus.route_source;
      board.check_decision(seen);
    end
  end

  // Returns at the accepting edge with valid still high, so back-to-back
  // packets keep valid asserted.
  task automatic send_packet(logic [FLAG_W-1:0] flags, logic has_id, logic [TAG_W-1:0] tag);
    int gap;
    gap = $urandom_range(0, pkt_gap_max);
    if (gap > 0) begin
      pkt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_bus.valid          <= 1'b1;
    pkt_bus.flag_word      <= flags;
    pkt_bus.carries_source <= has_id;
    pkt_bus.source_tag     <= tag;
    do @(posedge clk); while (pkt_bus.ready !== 1'b1);
    board.note_packet(flags, has_id, tag);
  endtask

  task automatic drain_results();
    pkt_bus.valid <= 1'b0;
    while (board.pending_decisions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the route count and all four masks from cur_count and cur_mask.
  task automatic load_config();
    prm_pkg::cfg_reg_t     reg_idx;
    logic [CFG_DATA_W-1:0] value;
    reg_idx = prm_pkg::REG_ROUTE_COUNT;
    do begin
      if (reg_idx == prm_pkg::REG_ROUTE_COUNT) value = CFG_DATA_W'(cur_count);
      else value = cur_mask[int'(reg_idx) - 1];
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= reg_idx;
      cfg_bus.data  <= value;
      do @(posedge clk); while (cfg_bus.ready !== 1'b1);
      board.set_register(reg_idx, value);
      reg_idx = reg_idx.next();
    end while (reg_idx != prm_pkg::REG_ROUTE_COUNT);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    int               pick;
    int               route;
    logic [FLAG_W-1:0] flags;
    logic             has_id;
    logic [TAG_W-1:0] tag;

    rst                    <= 1'b1;
    pkt_bus.valid          <= 1'b0;
    pkt_bus.flag_word      <= '0;
    pkt_bus.carries_source <= 1'b0;
    pkt_bus.source_tag     <= '0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= prm_pkg::REG_ROUTE_COUNT;
    cfg_bus.data           <= '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = $urandom;
    tag_pool[3] = $urandom;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Right after reset no route is installed, so everything is dropped.
    send_packet(16'hFFFF, 1'b1, tag_pool[2]);
    drain_results();

    // Route 0 needs bit 0, route 1 takes anything.
    cur_count = 3'd2;
    cur_mask[0] = 16'h0001;
    cur_mask[1] = 16'h0000;
    cur_mask[2] = 16'hFFFF;
    cur_mask[3] = 16'hFFFF;
    load_config();
    send_packet(16'h0000, 1'b0, tag_pool[3]);
    send_packet(16'h0000, 1'b1, tag_pool[3]);
    send_packet(16'h0001, 1'b1, tag_pool[2]);
    // Route 0 rejects a packet without id; route 1 would take it but is not tried.
    send_packet(16'h0001, 1'b0, '0);
    send_packet(16'hFFFF, 1'b1, tag_pool[2]);
    send_packet(16'hFFFF, 1'b1, ~tag_pool[2]);
    drain_results();

    // A route count above the number of routes acts as all routes.
    cur_count = 3'd7;
    cur_mask[0] = 16'hFFFF;
    cur_mask[1] = 16'hFFFF;
    cur_mask[2] = 16'h8000;
    cur_mask[3] = 16'h0000;
    load_config();
    send_packet(16'h0000, 1'b1, 32'hFFFF_FFFF);
    send_packet(16'h8000, 1'b1, 32'h0000_0000);
    send_packet(16'h8000, 1'b1, 32'h0000_0000);
    send_packet(16'hFFFF, 1'b0, '0);
    send_packet(16'h7FFF, 1'b1, 32'hFFFF_FFFF);
    send_packet(16'h7FFF, 1'b1, 32'hFFFF_FFFE);
    drain_results();

    cur_count = 3'd0;
    cur_mask[0] = FLAG_W'($urandom);
    cur_mask[1] = FLAG_W'($urandom);
    cur_mask[2] = FLAG_W'($urandom);
    cur_mask[3] = FLAG_W'($urandom);
    load_config();
    send_packet(16'hFFFF, 1'b1, tag_pool[3]);
    send_packet(16'h0000, 1'b0, '0);
    drain_results();

    cur_count = 3'd4;
    foreach (cur_mask[k]) cur_mask[k] = 16'h0000;
    load_config();
    send_packet(16'hAAAA, 1'b1, tag_pool[2]);
    send_packet(16'h5555, 1'b0, '0);
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) cur_count = 3'd0;
      else if (pick == 1) cur_count = COUNT_W'($urandom_range(5, 7));
      else cur_count = COUNT_W'($urandom_range(1, 4));
      foreach (cur_mask[k]) begin
        case ($urandom_range(0, 5))
          0: cur_mask[k] = 16'h0000;
          1: cur_mask[k] = 16'hFFFF;
          2: cur_mask[k] = FLAG_W'($urandom);
          default: cur_mask[k] = FLAG_W'($urandom & $urandom & $urandom);
        endcase
      end
      // Every third phase runs with no gaps and no back-pressure.
      pkt_gap_max   = (ph % 3 == 0) ? 0 : 6;
      res_stall_max = (ph % 3 == 0) ? 0 : 6;
      load_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick  = $urandom_range(0, 9);
        route = $urandom_range(0, MASK_REGS - 1);
        if (pick == 0) flags = FLAG_W'($urandom);
        else if (pick == 1) flags = '1;
        else if (pick == 2) flags = '0;
        else flags = cur_mask[route] | FLAG_W'($urandom & $urandom);
        has_id = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 7) tag = tag_pool[$urandom_range(0, POOL - 1)];
        else tag = $urandom;
        send_packet(flags, has_id, tag);
        if (n == PHASE_ITEMS / 2 && ph % 2 == 1) drain_results();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending_decisions.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
